// File: src/fau_pkg.sv
// shared types, constants and helpers of the fraction arithmetic unit
`timescale 1ns / 1ps
package fau_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam logic [63:0] LIM = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // classified transaction as held in the queue
  typedef struct packed {
    logic [1:0]  cmd;
    logic        err;
    logic        san;
    logic        sad;
    logic        sbn;
    logic        sbd;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [31:0] bd;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// File: src/fraction_arithmetic_unit_top.sv
// top level of the fraction arithmetic unit
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  cmd, a_num, a_den, b_num, b_den
//  out_     output     out_valid / out_stall res_num, res_den, status
//
// in the back end a transaction passes the multiply states, the sum state, the
// binary gcd loop and the 64-step paired divider before its result is
// registered; error transactions go from idle straight to the done state.
// the front queue holds two transactions, so input keeps flowing while the
// back end works or a result waits. reset is synchronous and active low.
`timescale 1ns / 1ps
module fraction_arithmetic_unit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic [1:0]          out_status
);

  fau_pkg::q_head_t q_head;
  logic             q_pop;

  fau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_a_num ($unsigned(in_a_num)),
    .in_a_den ($unsigned(in_a_den)),
    .in_b_num ($unsigned(in_b_num)),
    .in_b_den ($unsigned(in_b_den)),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  fau_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule

// File: src/fau_front.sv
// front end: sign/magnitude split, error classification and a two-entry queue
`timescale 1ns / 1ps
module fau_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [31:0]          in_a_num,
  input  logic [31:0]          in_a_den,
  input  logic [31:0]          in_b_num,
  input  logic [31:0]          in_b_den,
  output fau_pkg::q_head_t     q_head,
  input  logic                 q_pop
);

  fau_pkg::item_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  fau_pkg::item_t new_item;
  logic           push;

  always_comb begin
    new_item.cmd = in_cmd;
    new_item.san = in_a_num[31];
    new_item.sad = in_a_den[31];
    new_item.sbn = in_b_num[31];
    new_item.sbd = in_b_den[31];
    new_item.an  = fau_pkg::mag32(in_a_num);
    new_item.ad  = fau_pkg::mag32(in_a_den);
    new_item.bn  = fau_pkg::mag32(in_b_num);
    new_item.bd  = fau_pkg::mag32(in_b_den);
    new_item.err = (in_a_den == 32'd0) || (in_b_den == 32'd0) ||
                   ((in_cmd == fau_pkg::CMD_DIV) && (in_b_num == 32'd0));
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head.valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) && !q_pop |=> count_r == 2'd2)
    else $error("queue count lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) && !push |=> count_r == 2'd0)
    else $error("queue count grew without a push");

endmodule

// File: src/fau_back.sv
// back end: shared multiplier, binary gcd and paired bit-serial division
`timescale 1ns / 1ps
module fau_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fau_pkg::q_head_t     q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_res_num,
  output logic [30:0]          out_res_den,
  output logic [1:0]           out_status
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_MUL3 = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_GCD  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  fau_pkg::item_t item_r;
  logic [63:0]    p1_r, p2_r, p3_r;
  logic [63:0]    x_r, y_r;
  logic [5:0]     k_r;
  logic [63:0]    g_r;
  logic [63:0]    qn_r, qd_r;
  logic [63:0]    rn_r, rd_r;
  logic [5:0]     cnt_r;
  logic           sn_r, sd_r;
  logic           out_valid_r;
  logic [31:0]    res_num_r;
  logic [30:0]    res_den_r;
  logic [1:0]     status_r;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic           s1, s2, sd;
  logic [64:0]    rn_sh, rd_sh;
  logic [64:0]    rn_sub, rd_sub;
  logic           out_free;
  logic           fin_sn;
  logic           ovf;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_head.valid;

  // operand choice for the single 32x32 multiplier
  always_comb begin
    mul_a = item_r.an;
    mul_b = (item_r.cmd == fau_pkg::CMD_MUL) ? item_r.bn : item_r.bd;
    case (state_r)
      S_MUL2: begin
        mul_a = item_r.bn;
        mul_b = item_r.ad;
      end
      S_MUL3: begin
        mul_a = item_r.ad;
        mul_b = (item_r.cmd == fau_pkg::CMD_DIV) ? item_r.bn : item_r.bd;
      end
      default: begin
      end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    s1 = (item_r.cmd == fau_pkg::CMD_MUL) ? (item_r.san ^ item_r.sbn)
                                          : (item_r.san ^ item_r.sbd);
    s2 = item_r.sbn ^ item_r.sad ^ (item_r.cmd == fau_pkg::CMD_SUB);
    sd = (item_r.cmd == fau_pkg::CMD_DIV) ? (item_r.sad ^ item_r.sbn)
                                          : (item_r.sad ^ item_r.sbd);
  end

  // restoring division step, numerator and denominator side by side
  always_comb begin
    rn_sh  = {rn_r, qn_r[63]};
    rd_sh  = {rd_r, qd_r[63]};
    rn_sub = rn_sh - {1'b0, g_r};
    rd_sub = rd_sh - {1'b0, g_r};
  end

  always_comb begin
    fin_sn = sn_r ^ sd_r;
    if (qn_r == 64'd0) begin
      fin_sn = 1'b0;
    end
    ovf = (qd_r > fau_pkg::LIM) || (!fin_sn && (qn_r > fau_pkg::LIM)) ||
          (fin_sn && (qn_r > fau_pkg::LIM + 64'd1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_head.valid) state_nxt = q_head.item.err ? S_DONE : S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_GCD;
      S_GCD:  if (x_r == 64'd0) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd63) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          item_r <= q_head.item;
        end
      end
      S_MUL1: p1_r <= prod;
      S_MUL2: p2_r <= prod;
      S_MUL3: p3_r <= prod;
      S_SUM: begin
        sd_r <= sd;
        if (item_r.cmd == fau_pkg::CMD_ADD || item_r.cmd == fau_pkg::CMD_SUB) begin
          if (s1 == s2) begin
            x_r <= p1_r + p2_r;
            sn_r <= s1;
          end else if (p1_r >= p2_r) begin
            x_r <= p1_r - p2_r;
            sn_r <= s1;
          end else begin
            x_r <= p2_r - p1_r;
            sn_r <= s2;
          end
        end else begin
          x_r  <= p1_r;
          sn_r <= s1;
        end
        y_r  <= p3_r;
        k_r  <= 6'd0;
      end
      S_GCD: begin
        if (x_r == 64'd0) begin
          g_r   <= y_r << k_r;
          rn_r  <= 64'd0;
          rd_r  <= 64'd0;
          cnt_r <= 6'd0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 6'd1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
        // keep the original magnitudes as dividends
        if (x_r == 64'd0) begin
          qn_r <= qn_r;
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (!rn_sub[64]) begin
          rn_r <= rn_sub[63:0];
          qn_r <= {qn_r[62:0], 1'b1};
        end else begin
          rn_r <= rn_sh[63:0];
          qn_r <= {qn_r[62:0], 1'b0};
        end
        if (!rd_sub[64]) begin
          rd_r <= rd_sub[63:0];
          qd_r <= {qd_r[62:0], 1'b1};
        end else begin
          rd_r <= rd_sh[63:0];
          qd_r <= {qd_r[62:0], 1'b0};
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (item_r.err) begin
            res_num_r <= 32'd0;
            res_den_r <= 31'd0;
            status_r  <= fau_pkg::ST_ZERO;
          end else if (ovf) begin
            res_num_r <= 32'd0;
            res_den_r <= 31'd0;
            status_r  <= fau_pkg::ST_OVF;
          end else begin
            res_num_r <= fin_sn ? (32'd0 - qn_r[31:0]) : qn_r[31:0];
            res_den_r <= qd_r[30:0];
            status_r  <= fau_pkg::ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    // dividends are the reduced-to-be magnitudes captured at the sum stage
    if (state_r == S_SUM) begin
      if (item_r.cmd == fau_pkg::CMD_ADD || item_r.cmd == fau_pkg::CMD_SUB) begin
        if (s1 == s2) begin
          qn_r <= p1_r + p2_r;
        end else if (p1_r >= p2_r) begin
          qn_r <= p1_r - p2_r;
        end else begin
          qn_r <= p2_r - p1_r;
        end
      end else begin
        qn_r <= p1_r;
      end
      qd_r <= p3_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = $signed(res_num_r);
  assign out_res_den = res_den_r;
  assign out_status  = status_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> (y_r != 64'd0))
    else $error("gcd lost its nonzero operand");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == 6'd63) |=> (state_r == S_DONE))
    else $error("division did not finish after 64 steps");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == fau_pkg::ST_OK) |-> (res_den_r != 31'd0))
    else $error("ok result with zero denominator");

endmodule
